// File: src/bde_pkg.sv
// Package for the battery drain estimator: widths, reset values, register indexes,
// sequencer states and the divider request/response structs. No dependencies.
`default_nettype none
package bde_pkg;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int DIV_W = 64;
   localparam int DIV_CNT_W = 7;

   localparam logic [CSR_IDX_W-1:0] REG_WIN_AWAKE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WIN_SLEEP = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ALPHA_AWAKE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ALPHA_SLEEP = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DRAIN_THR = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ETA_LIMIT = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_KNEE = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_FULL = 3'd7;

   localparam logic [31:0] RST_WIN_AWAKE = 32'd300000;
   localparam logic [31:0] RST_WIN_SLEEP = 32'd1200000;
   localparam logic [16:0] RST_ALPHA_AWAKE = 17'd22938;
   localparam logic [16:0] RST_ALPHA_SLEEP = 17'd13107;
   localparam logic signed [16:0] RST_DRAIN_THR = -17'sd13;
   localparam logic [15:0] RST_ETA_LIMIT = 16'd10080;
   localparam logic [15:0] RST_KNEE = 16'd20480;
   localparam logic [15:0] RST_FULL = 16'd24064;

   typedef enum logic [3:0] {
      ST_IDLE, ST_PCT_MUL, ST_PCT_DIV, ST_PCT_WAIT, ST_CHG_DIV, ST_CHG_WAIT,
      ST_VLT_DIV, ST_VLT_WAIT, ST_CHG_SMOOTH, ST_VLT_SMOOTH, ST_ETA_DIV,
      ST_ETA_WAIT, ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;
endpackage
`default_nettype wire

// File: src/bde_divider.sv
// Radix-2 restoring unsigned divider shared by every quotient of the estimator.
// Depends on bde_pkg for widths and request/response structs.
`default_nettype none
module bde_divider (
   input wire logic clock,
   input wire logic reset,
   input wire bde_pkg::div_req_type req,
   output bde_pkg::div_rsp_type rsp
);
   import bde_pkg::*;

   logic [DIV_W-1:0] quo_ff, quo_in, den_ff, den_in;
   logic [DIV_W:0] rem_ff, rem_in, trial;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      trial = {rem_ff[DIV_W-1:0], quo_ff[DIV_W-1]} - {1'b0, den_ff};
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         quo_in = req.dividend;
         den_in = req.divisor;
         rem_in = '0;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial[DIV_W]) begin
            rem_in = {rem_ff[DIV_W-1:0], quo_ff[DIV_W-1]};
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign rsp.quotient = quo_ff;

   assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("divider busy at done");
   assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !req.start) |-> (cnt_ff < DIV_CNT_W'(DIV_W)))
      else $error("divider count overrun");
   assert property (@(posedge clock) disable iff (reset) done_ff |-> $past(busy_ff))
      else $error("done without run");
endmodule
`default_nettype wire

// File: src/battery_drain_estimator_unit.sv
// Battery drain estimator: one result word per poll word. A poll whose percent
// needs no stretching and that sets a baseline or stays inside the window skips
// the divider; a stretched percent needs the 64-step shared divider. Closing a
// window adds three more divisions (two slopes and the remaining-time estimate)
// plus the two smoothing steps. A stall on the result side holds the result.
// Input stall stays high while a poll is in work or its result waits, so a new
// poll is taken only after the last result is gone. Depends on bde_pkg and
// bde_divider.
`default_nettype none
module battery_drain_estimator_unit (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire logic [15:0] req_soc_raw,
   input wire logic [15:0] req_cell_voltage_raw,
   input wire logic [39:0] req_time_ms,
   input wire logic req_screen_awake,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output logic [6:0] rsp_display_percent,
   output logic rsp_percent_changed,
   output logic rsp_rate_updated,
   output logic signed [31:0] rsp_charge_rate,
   output logic signed [39:0] rsp_voltage_rate,
   output logic signed [16:0] rsp_eta_minutes,
   input wire logic csr_write,
   input wire logic [bde_pkg::CSR_IDX_W-1:0] csr_index,
   input wire logic [bde_pkg::CSR_DATA_W-1:0] csr_data
);
   import bde_pkg::*;

   logic [31:0] win_awake_ff, win_sleep_ff;
   logic [16:0] wgt_awake_ff, wgt_sleep_ff;
   logic signed [16:0] thr_ff;
   logic [15:0] eta_lim_ff, knee_ff, full_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_awake_ff <= RST_WIN_AWAKE;
         win_sleep_ff <= RST_WIN_SLEEP;
         wgt_awake_ff <= RST_ALPHA_AWAKE;
         wgt_sleep_ff <= RST_ALPHA_SLEEP;
         thr_ff <= RST_DRAIN_THR;
         eta_lim_ff <= RST_ETA_LIMIT;
         knee_ff <= RST_KNEE;
         full_ff <= RST_FULL;
      end else if (csr_write) begin
         case (csr_index)
            REG_WIN_AWAKE: win_awake_ff <= csr_data;
            REG_WIN_SLEEP: win_sleep_ff <= csr_data;
            REG_ALPHA_AWAKE: wgt_awake_ff <= csr_data[16:0];
            REG_ALPHA_SLEEP: wgt_sleep_ff <= csr_data[16:0];
            REG_DRAIN_THR: thr_ff <= csr_data[16:0];
            REG_ETA_LIMIT: eta_lim_ff <= csr_data[15:0];
            REG_KNEE: knee_ff <= csr_data[15:0];
            REG_FULL: full_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   state_type state_ff, state_in;
   logic [15:0] soc_ff, volt_ff;
   logic [39:0] now_ff;
   logic awake_ff;
   logic base_valid_ff, base_valid_in;
   logic [39:0] base_time_ff, base_time_in;
   logic [15:0] base_soc_ff, base_soc_in, base_volt_ff, base_volt_in;
   logic signed [31:0] sm_chg_ff, sm_chg_in;
   logic signed [39:0] sm_vlt_ff, sm_vlt_in;
   logic signed [16:0] eta_ff, eta_in;
   logic [7:0] prev_pct_ff, prev_pct_in;
   logic [6:0] pct_ff, pct_in;
   logic upd_ff, upd_in, chg_ff, chg_in;
   logic signed [39:0] raw_vlt_ff, raw_vlt_in;
   logic signed [31:0] raw_chg_ff, raw_chg_in;
   logic [39:0] nx_ff, nx_in;

   div_req_type dreq;
   div_rsp_type drsp;
   bde_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   logic [39:0] dt;
   logic [31:0] win;
   logic [16:0] alpha_sel, alpha;
   logic [15:0] dknee, dfull;
   logic [16:0] span;
   logic signed [16:0] dsoc, dvolt;
   logic [63:0] abs_num, mag, mul_a, mul_b;
   logic [63:0] quo_sat;
   logic signed [63:0] sample, oldv, smooth_sum, smooth_t, smooth_r;
   logic [8:0] pct_wide;
   logic [32:0] eta_r;
   logic close_win, accept, stretch, pct_ready;

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign dt = now_ff - base_time_ff;
   assign win = awake_ff ? win_awake_ff : win_sleep_ff;
   assign alpha_sel = awake_ff ? wgt_awake_ff : wgt_sleep_ff;
   assign alpha = alpha_sel[16] ? 17'd65536 : alpha_sel;
   assign close_win = base_valid_ff && (dt != '0) && (dt >= {8'd0, win});
   assign dknee = soc_ff - knee_ff;
   assign dfull = full_ff - knee_ff;
   assign span = 17'd25600 - {1'b0, knee_ff};
   assign dsoc = $signed({1'b0, soc_ff}) - $signed({1'b0, base_soc_ff});
   assign dvolt = $signed({1'b0, volt_ff}) - $signed({1'b0, base_volt_ff});
   assign eta_r = -{sm_chg_ff[31], sm_chg_ff};
   assign stretch = (soc_ff > knee_ff) && (full_ff > knee_ff) && (knee_ff < 16'd25600);
   assign pct_ready = !stretch || drsp.done;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_PCT_MUL: begin
            mul_a = {48'd0, knee_ff};
            mul_b = {48'd0, dfull};
         end
         ST_PCT_DIV: begin
            mul_a = {48'd0, dknee};
            mul_b = {47'd0, span};
         end
         ST_CHG_DIV: begin
            mul_a = {47'd0, dsoc[16] ? -dsoc : dsoc};
            mul_b = 64'd3600000;
         end
         ST_VLT_DIV: begin
            mul_a = {47'd0, dvolt[16] ? -dvolt : dvolt};
            mul_b = 64'd72000000;
         end
         default: ;
      endcase
      mag = 64'(mul_a[31:0] * mul_b[31:0]);
   end

   assign abs_num = mag;

   always_comb begin
      oldv = (state_ff == ST_VLT_SMOOTH) ? 64'(sm_vlt_ff) : 64'(sm_chg_ff);
      sample = (state_ff == ST_VLT_SMOOTH) ? 64'(raw_vlt_ff) : 64'(raw_chg_ff);
      smooth_sum = $signed({47'd0, alpha}) * sample
         + $signed(64'd65536 - {47'd0, alpha}) * oldv;
      smooth_t = smooth_sum + 64'sd32768;
      smooth_r = smooth_t >>> 16;
   end

   always_comb begin
      quo_sat = drsp.quotient;
      pct_wide = (soc_ff <= knee_ff) ? 9'(({1'b0, soc_ff} + 17'd128) >> 8) : 9'd100;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) state_in = ST_PCT_MUL;
         ST_PCT_MUL: state_in = ST_PCT_DIV;
         ST_PCT_DIV: state_in = ST_PCT_WAIT;
         ST_PCT_WAIT: if (pct_ready) state_in = close_win ? ST_CHG_DIV : ST_DONE;
         ST_CHG_DIV: state_in = ST_CHG_WAIT;
         ST_CHG_WAIT: if (drsp.done) state_in = ST_VLT_DIV;
         ST_VLT_DIV: state_in = ST_VLT_WAIT;
         ST_VLT_WAIT: if (drsp.done) state_in = ST_CHG_SMOOTH;
         ST_CHG_SMOOTH: state_in = ST_VLT_SMOOTH;
         ST_VLT_SMOOTH: state_in = ST_ETA_DIV;
         ST_ETA_DIV: state_in = ST_ETA_WAIT;
         ST_ETA_WAIT: if (drsp.done) state_in = ST_DONE;
         ST_DONE: if (!rsp_stall) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      dreq = '0;
      base_valid_in = base_valid_ff;
      base_time_in = base_time_ff;
      base_soc_in = base_soc_ff;
      base_volt_in = base_volt_ff;
      sm_chg_in = sm_chg_ff;
      sm_vlt_in = sm_vlt_ff;
      eta_in = eta_ff;
      prev_pct_in = prev_pct_ff;
      pct_in = pct_ff;
      upd_in = upd_ff;
      chg_in = chg_ff;
      raw_chg_in = raw_chg_ff;
      raw_vlt_in = raw_vlt_ff;
      nx_in = nx_ff;
      case (state_ff)
         ST_IDLE: upd_in = 1'b0;
         ST_PCT_MUL: nx_in = 40'(mag);
         ST_PCT_DIV: begin
            if (stretch) begin
               dreq.start = 1'b1;
               dreq.dividend = 64'(2 * (64'(nx_ff) + mag) + 64'(dfull) * 256);
               dreq.divisor = 64'(dfull) * 512;
            end
         end
         ST_PCT_WAIT: if (pct_ready) begin
            if (stretch)
               pct_in = (quo_sat > 64'd100) ? 7'd100 : quo_sat[6:0];
            else
               pct_in = (pct_wide > 9'd100) ? 7'd100 : pct_wide[6:0];
            chg_in = ({1'b0, pct_in} != prev_pct_ff);
            prev_pct_in = {1'b0, pct_in};
            if (!base_valid_ff) begin
               base_valid_in = 1'b1;
               base_time_in = now_ff;
               base_soc_in = soc_ff;
               base_volt_in = volt_ff;
            end
         end
         ST_CHG_DIV, ST_VLT_DIV: begin
            dreq.start = 1'b1;
            dreq.dividend = abs_num;
            dreq.divisor = 64'(dt);
         end
         ST_CHG_WAIT: if (drsp.done) begin
            if (dsoc[16])
               raw_chg_in = (quo_sat > 64'd2147483648) ? 32'h80000000 : 32'(-quo_sat);
            else
               raw_chg_in = (quo_sat > 64'd2147483647) ? 32'h7fffffff : 32'(quo_sat);
         end
         ST_VLT_WAIT: if (drsp.done) begin
            if (dvolt[16])
               raw_vlt_in = (quo_sat > 64'd549755813888) ? 40'h8000000000 : 40'(-quo_sat);
            else
               raw_vlt_in = (quo_sat > 64'd549755813887) ? 40'h7fffffffff : 40'(quo_sat);
         end
         ST_CHG_SMOOTH: sm_chg_in = (sm_chg_ff == 0) ? raw_chg_ff : 32'(smooth_r);
         ST_VLT_SMOOTH: sm_vlt_in = (sm_vlt_ff == 0) ? raw_vlt_ff : 40'(smooth_r);
         ST_ETA_DIV: begin
            dreq.start = 1'b1;
            dreq.dividend = 64'(soc_ff) * 120 + 64'(eta_r);
            dreq.divisor = {30'd0, eta_r, 1'b0};
         end
         ST_ETA_WAIT: if (drsp.done) begin
            eta_in = -17'sd1;
            if (sm_chg_ff < 32'(thr_ff) && sm_chg_ff < 0 && quo_sat != 0
                && quo_sat < 64'(eta_lim_ff))
               eta_in = 17'(quo_sat);
            base_time_in = now_ff;
            base_soc_in = soc_ff;
            base_volt_in = volt_ff;
            upd_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         base_valid_ff <= 1'b0;
         base_time_ff <= '0;
         base_soc_ff <= '0;
         base_volt_ff <= '0;
         sm_chg_ff <= '0;
         sm_vlt_ff <= '0;
         eta_ff <= -17'sd1;
         prev_pct_ff <= 8'hff;
      end else begin
         state_ff <= state_in;
         base_valid_ff <= base_valid_in;
         base_time_ff <= base_time_in;
         base_soc_ff <= base_soc_in;
         base_volt_ff <= base_volt_in;
         sm_chg_ff <= sm_chg_in;
         sm_vlt_ff <= sm_vlt_in;
         eta_ff <= eta_in;
         prev_pct_ff <= prev_pct_in;
      end
      if (accept) begin
         soc_ff <= req_soc_raw;
         volt_ff <= req_cell_voltage_raw;
         now_ff <= req_time_ms;
         awake_ff <= req_screen_awake;
      end
      pct_ff <= pct_in;
      upd_ff <= upd_in;
      chg_ff <= chg_in;
      raw_chg_ff <= raw_chg_in;
      raw_vlt_ff <= raw_vlt_in;
      nx_ff <= nx_in;
   end

   assign rsp_valid = (state_ff == ST_DONE);
   assign rsp_display_percent = pct_ff;
   assign rsp_percent_changed = chg_ff;
   assign rsp_rate_updated = upd_ff;
   assign rsp_charge_rate = sm_chg_ff;
   assign rsp_voltage_rate = sm_vlt_ff;
   assign rsp_eta_minutes = eta_ff;

   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> (pct_ff <= 7'd100))
      else $error("percent above 100");
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> req_stall)
      else $error("input open with result");
   assert property (@(posedge clock) disable iff (reset) drsp.busy |-> (state_ff != ST_IDLE))
      else $error("divider idle run");
endmodule
`default_nettype wire
